>>> rtl/sid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sid_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_PROBE = 2'd2;

    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_NEW  = 2'd2;
    localparam logic [1:0] STATUS_SEEN = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] item_value;
    } sid_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] common_value;
    } sid_result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN_REF,
        S_SCAN_EMIT
    } sid_state_t;

endpackage

`default_nettype wire

>>> rtl/set_intersection_dedup_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Set intersection with duplicate removal.
// A transaction is taken on item when start is high and busy is low. Each
// transaction produces exactly one result, shown on result for one cycle
// while done is high; the receiver cannot stall, so the result is gone after
// that cycle. A new transaction may be taken in the same cycle that done shows
// the previous result.
// Clear, load, the unused opcode and probes of an empty store finish at once:
// done rises in the cycle after the transaction. A probe walks the reference
// memory one entry per cycle until it finds a match, then walks the emitted
// memory the same way; busy stays high for the walk. Both memories have one
// synchronous read port.
// Reset empties both stores by clearing their counts; no clearing pass runs,
// and the block takes a transaction in the first cycle after reset.
module set_intersection_dedup_core
    import sid_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire sid_item_t   item,
    output logic             done,
    output sid_result_t      result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    logic [31:0] ref_mem  [CAPACITY];
    logic [31:0] emit_mem [CAPACITY];

    sid_state_t  state_reg, state_next;
    logic [CW-1:0] ref_cnt_reg, ref_cnt_next;
    logic [CW-1:0] emit_cnt_reg, emit_cnt_next;
    logic [CW-1:0] addr_reg, addr_next;
    logic          pend_reg, pend_next;
    logic [31:0]   key_reg, key_next;
    logic          done_reg, done_next;
    sid_result_t   result_reg, result_next;

    logic          accept;
    logic          ref_we;
    logic          emit_we;
    logic [31:0]   ref_rdata;
    logic [31:0]   emit_rdata;
    logic [CW-1:0] cur_cnt;
    logic [31:0]   cur_data;
    logic          issue;
    logic          hit;
    logic          miss_end;
    logic          probe_start;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign done     = done_reg;
    assign result   = result_reg;

    assign cur_cnt  = (state_reg == S_SCAN_REF) ? ref_cnt_reg : emit_cnt_reg;
    assign cur_data = (state_reg == S_SCAN_REF) ? ref_rdata : emit_rdata;
    assign issue    = busy && (addr_reg != cur_cnt);
    // The read data belongs to the address issued in the previous cycle.
    assign hit      = pend_reg && (cur_data == key_reg);
    assign miss_end = !pend_reg && (addr_reg == cur_cnt);
    assign probe_start = accept && (item.opcode == OP_PROBE) && (ref_cnt_reg != '0);

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[ref_cnt_reg[AW-1:0]] <= $unsigned(item.item_value);
        end
        if (issue && (state_reg == S_SCAN_REF))
        begin
            ref_rdata <= ref_mem[addr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_we)
        begin
            emit_mem[emit_cnt_reg[AW-1:0]] <= key_reg;
        end
        if (issue && (state_reg == S_SCAN_EMIT))
        begin
            emit_rdata <= emit_mem[addr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ref_cnt_reg  <= '0;
            emit_cnt_reg <= '0;
            addr_reg     <= '0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ref_cnt_reg  <= ref_cnt_next;
            emit_cnt_reg <= emit_cnt_next;
            addr_reg     <= addr_next;
            pend_reg     <= pend_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (probe_start)
                begin
                    state_next = S_SCAN_REF;
                end
            end
            S_SCAN_REF:
            begin
                if (hit)
                begin
                    state_next = S_SCAN_EMIT;
                end
                else if (miss_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN_EMIT:
            begin
                if (hit || miss_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ref_cnt_next = ref_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        addr_next = addr_reg;
        pend_next = 1'b0;
        key_next = key_reg;
        done_next = 1'b0;
        result_next.status = STATUS_DONE;
        result_next.common_value = '0;
        ref_we = 1'b0;
        emit_we = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                addr_next = '0;
                if (accept)
                begin
                    key_next = $unsigned(item.item_value);
                    done_next = !probe_start;
                    unique case (item.opcode)
                        OP_CLEAR:
                        begin
                            ref_cnt_next = '0;
                            emit_cnt_next = '0;
                        end
                        OP_LOAD:
                        begin
                            if (ref_cnt_reg == CAP_CNT)
                            begin
                                result_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                ref_we = 1'b1;
                                ref_cnt_next = ref_cnt_reg + CNT_ONE;
                            end
                        end
                        default:
                        begin
                            // Probes of an empty store and the unused opcode
                            // report done at once.
                        end
                    endcase
                end
            end
            S_SCAN_REF, S_SCAN_EMIT:
            begin
                pend_next = issue;
                if (issue)
                begin
                    addr_next = addr_reg + CNT_ONE;
                end
                if (hit)
                begin
                    addr_next = '0;
                    pend_next = 1'b0;
                    if (state_reg == S_SCAN_EMIT)
                    begin
                        done_next = 1'b1;
                        result_next.status = STATUS_SEEN;
                    end
                end
                else if (miss_end)
                begin
                    done_next = 1'b1;
                    if (state_reg == S_SCAN_EMIT)
                    begin
                        result_next.status = STATUS_NEW;
                        result_next.common_value = $signed(key_reg);
                        if (emit_cnt_reg != CAP_CNT)
                        begin
                            emit_we = 1'b1;
                            emit_cnt_next = emit_cnt_reg + CNT_ONE;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire
